// ===== sv/mps_pkg.sv =====
package mps_pkg;

    // Frame limits and storage geometry.
    localparam int unsigned MAX_PIXELS_LOG2 = 24;
    localparam int unsigned BINS            = 256;
    localparam int unsigned BIN_AW          = 8;
    localparam int unsigned COUNT_W         = MAX_PIXELS_LOG2 + 1;
    localparam int unsigned SUM_W           = 32;
    localparam int unsigned SQ_W            = 40;
    localparam int unsigned CUBE_W          = 49;
    localparam logic [7:0]  MIN_RESET       = 8'd255;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FLAT  = 2'd2;

    typedef struct packed {
        logic [7:0] pixel;
        logic       selected;
        logic       last;
    } sample_t;

    typedef struct packed {
        logic [24:0] pixel_count;
        logic [7:0]  min_value;
        logic [7:0]  max_value;
        logic [23:0] mean_q16;
        logic [29:0] variance_q16;
        logic [31:0] sum_total;
        logic [39:0] sum_of_squares;
        logic [24:0] positive_count;
        logic [24:0] zero_count;
        logic [7:0]  mode_value;
        logic signed [31:0] skewness_q16;
        logic [1:0]  status;
    } result_t;

    // End-of-frame calculation steps, run in this order.
    typedef enum logic [3:0] {
        STEP_N2,
        STEP_NS2,
        STEP_S1SQ,
        STEP_MEAN,
        STEP_VAR,
        STEP_T1,
        STEP_N3S1,
        STEP_T2,
        STEP_T3,
        STEP_U,
        STEP_SQRT,
        STEP_V
    } step_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIST,
        ST_SCAN,
        ST_START,
        ST_WAIT,
        ST_FORM
    } ctrl_state_t;

    typedef struct packed {
        logic  accept;
        logic  hist_wr;
        logic  scan_run;
        logic  arith_start;
        step_t step;
        logic  load_result;
        logic  clear;
    } dp_cmd_t;

    typedef struct packed {
        logic take;
        logic last;
        logic scan_end;
        logic arith_done;
        logic n_zero;
        logic d_zero;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/mps_ram.sv =====
module mps_ram #(
    parameter int unsigned WIDTH = mps_pkg::COUNT_W,
    parameter int unsigned DEPTH = mps_pkg::BINS,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mps_arith.sv =====
module mps_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mps_pkg::arith_op_t  op,
    input  logic [127:0]        opa,
    input  logic [63:0]         opb,
    output logic                done,
    output logic [127:0]        res
);

    localparam logic [7:0] MUL_STEPS  = 8'd64;
    localparam logic [7:0] DIV_STEPS  = 8'd128;
    localparam logic [7:0] SQRT_STEPS = 8'd48;

    mps_pkg::arith_op_t op_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [7:0]   cnt_reg;
    logic [127:0] acc_reg;
    logic [127:0] shf_reg;
    logic [63:0]  mpl_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  den_reg;
    logic [47:0]  root_reg;

    logic [64:0]  div_sh;
    logic         div_ge;
    logic [64:0]  div_diff;
    logic [51:0]  sq_sh;
    logic [51:0]  sq_trial;
    logic         sq_ge;
    logic [51:0]  sq_diff;

    // Restoring divide and bitwise square root step logic.
    always_comb
    begin
        div_sh   = {rem_reg, shf_reg[127]};
        div_ge   = div_sh >= {1'b0, den_reg};
        div_diff = div_sh - {1'b0, den_reg};
        sq_sh    = {rem_reg[49:0], shf_reg[127:126]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
        sq_diff  = sq_sh - sq_trial;
    end

    // Control: one iteration per cycle, done pulses after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= mps_pkg::OP_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= op;
                case (op)
                    mps_pkg::OP_MUL:  cnt_reg <= MUL_STEPS;
                    mps_pkg::OP_DIV:  cnt_reg <= DIV_STEPS;
                    mps_pkg::OP_SQRT: cnt_reg <= SQRT_STEPS;
                    default:          cnt_reg <= MUL_STEPS;
                endcase
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of the shared unit.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            den_reg  <= opb;
            mpl_reg  <= opa[63:0];
            case (op)
                mps_pkg::OP_MUL:  shf_reg <= {64'd0, opb};
                mps_pkg::OP_DIV:  shf_reg <= opa;
                mps_pkg::OP_SQRT: shf_reg <= {opa[95:0], 32'd0};
                default:          shf_reg <= opa;
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                mps_pkg::OP_MUL:
                begin
                    if (mpl_reg[0])
                    begin
                        acc_reg <= acc_reg + shf_reg;
                    end
                    shf_reg <= {shf_reg[126:0], 1'b0};
                    mpl_reg <= {1'b0, mpl_reg[63:1]};
                end
                mps_pkg::OP_DIV:
                begin
                    rem_reg <= div_ge ? div_diff[63:0] : div_sh[63:0];
                    shf_reg <= {shf_reg[126:0], div_ge};
                end
                mps_pkg::OP_SQRT:
                begin
                    rem_reg  <= {14'd0, (sq_ge ? sq_diff[49:0] : sq_sh[49:0])};
                    root_reg <= {root_reg[46:0], sq_ge};
                    shf_reg  <= {shf_reg[125:0], 2'b00};
                end
                default:
                begin
                    shf_reg <= shf_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (op_reg)
            mps_pkg::OP_MUL:  res = acc_reg;
            mps_pkg::OP_DIV:  res = shf_reg;
            mps_pkg::OP_SQRT: res = {80'd0, root_reg};
            default:          res = acc_reg;
        endcase
    end

    assign done = done_reg;

endmodule

// ===== sv/mps_datapath.sv =====
module mps_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mps_pkg::sample_t     sample,
    input  mps_pkg::dp_cmd_t     cmd,
    output mps_pkg::dp_status_t  status,
    output logic                 result_valid,
    input  logic                 result_ready,
    output mps_pkg::result_t     result
);

    localparam int unsigned CW = mps_pkg::COUNT_W;
    localparam logic [8:0]  SCAN_LAST = 9'(mps_pkg::BINS);

    // Accumulators.
    logic [CW-1:0]               count_reg;
    logic [mps_pkg::SUM_W-1:0]   sum_reg;
    logic [mps_pkg::SQ_W-1:0]    sq_reg;
    logic [mps_pkg::CUBE_W-1:0]  cube_reg;
    logic [7:0]                  min_reg;
    logic [7:0]                  max_reg;
    logic [CW-1:0]               pos_reg;
    logic [CW-1:0]               zero_reg;
    logic [7:0]                  px_reg;
    logic [15:0]                 px_sq_reg;

    // Histogram store and its valid bits.
    logic [mps_pkg::BINS-1:0]    valid_bits_reg;
    logic                        rvalid_reg;
    logic [CW-1:0]               rdata;
    logic [CW-1:0]               bin_value;
    logic [mps_pkg::BIN_AW-1:0]  raddr;
    logic                        re;

    // Mode search.
    logic [8:0]                  scan_cnt_reg;
    logic [8:0]                  scan_prev;
    logic [CW-1:0]               best_reg;
    logic [7:0]                  mode_reg;

    // End-of-frame intermediates.
    logic [63:0]                 n2_reg;
    logic [63:0]                 ns2_reg;
    logic [63:0]                 s1sq_reg;
    logic [63:0]                 d_reg;
    logic [23:0]                 mean_reg;
    logic [29:0]                 var_reg;
    logic [127:0]                t_reg;
    logic [63:0]                 tmp_reg;
    logic [127:0]                u_reg;
    logic [47:0]                 s_reg;
    logic [127:0]                v_reg;

    mps_pkg::arith_op_t          arith_op;
    logic [127:0]                opa;
    logic [63:0]                 opb;
    logic                        arith_done;
    logic [127:0]                arith_res;
    logic [127:0]                t_mag;
    logic [26:0]                 n_times3;

    mps_pkg::result_t            result_reg;
    mps_pkg::result_t            result_next;
    logic                        out_valid_reg;

    logic                        neg;
    logic [31:0]                 lim;
    logic                        sat;
    logic [31:0]                 skew_mag;
    logic                        n_zero;
    logic                        d_zero;

    assign n_zero = (count_reg == '0);
    assign d_zero = (d_reg == 64'd0);

    // Status towards the controller.
    always_comb
    begin
        status.take       = sample.selected & ~count_reg[CW-1];
        status.last       = sample.last;
        status.scan_end   = (scan_cnt_reg == SCAN_LAST);
        status.arith_done = arith_done;
        status.n_zero     = n_zero;
        status.d_zero     = d_zero;
        status.out_free   = ~out_valid_reg | result_ready;
    end

    // Histogram read port: the scan address during the scan, the pixel otherwise.
    assign raddr = cmd.scan_run ? scan_cnt_reg[7:0] : sample.pixel;
    assign re    = cmd.accept | (cmd.scan_run & ~scan_cnt_reg[8]);
    assign bin_value = rvalid_reg ? rdata : '0;

    mps_ram #(
        .WIDTH (CW),
        .DEPTH (mps_pkg::BINS)
    ) u_hist (
        .clk   (clk),
        .we    (cmd.hist_wr),
        .waddr (px_reg),
        .wdata (bin_value + CW'(1)),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_bits_reg <= '0;
        end
        else if (cmd.hist_wr)
        begin
            valid_bits_reg[px_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rvalid_reg <= valid_bits_reg[raddr];
        end
        if (cmd.accept)
        begin
            px_reg    <= sample.pixel;
            px_sq_reg <= 16'(sample.pixel) * 16'(sample.pixel);
        end
    end

    // Moment accumulation, in the cycle after the pixel is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            cube_reg  <= '0;
            min_reg   <= mps_pkg::MIN_RESET;
            max_reg   <= '0;
            pos_reg   <= '0;
            zero_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            cube_reg  <= '0;
            min_reg   <= mps_pkg::MIN_RESET;
            max_reg   <= '0;
            pos_reg   <= '0;
            zero_reg  <= '0;
        end
        else if (cmd.hist_wr)
        begin
            count_reg <= count_reg + CW'(1);
            sum_reg   <= sum_reg + mps_pkg::SUM_W'(px_reg);
            sq_reg    <= sq_reg + mps_pkg::SQ_W'(px_sq_reg);
            cube_reg  <= cube_reg +
                         (mps_pkg::CUBE_W'(px_sq_reg) * mps_pkg::CUBE_W'(px_reg));
            if (px_reg < min_reg)
            begin
                min_reg <= px_reg;
            end
            if (px_reg > max_reg)
            begin
                max_reg <= px_reg;
            end
            if (px_reg != 8'd0)
            begin
                pos_reg <= pos_reg + CW'(1);
            end
            else
            begin
                zero_reg <= zero_reg + CW'(1);
            end
        end
    end

    // Mode search: one bin per cycle, strict compare keeps the lowest index.
    assign scan_prev = scan_cnt_reg - 9'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            best_reg     <= '0;
            mode_reg     <= '0;
        end
        else if (cmd.clear)
        begin
            scan_cnt_reg <= '0;
            best_reg     <= '0;
            mode_reg     <= '0;
        end
        else if (!cmd.scan_run)
        begin
            scan_cnt_reg <= '0;
        end
        else
        begin
            if (!scan_cnt_reg[8])
            begin
                scan_cnt_reg <= scan_cnt_reg + 9'd1;
            end
            if ((scan_cnt_reg != 9'd0) && (bin_value > best_reg))
            begin
                best_reg <= bin_value;
                mode_reg <= scan_prev[7:0];
            end
        end
    end

    // Operand selection for the shared arithmetic unit.
    assign n_times3 = {1'b0, count_reg, 1'b0} + 27'(count_reg);
    assign t_mag    = t_reg[127] ? (~t_reg + 128'd1) : t_reg;

    always_comb
    begin
        arith_op = mps_pkg::OP_MUL;
        opa      = '0;
        opb      = '0;
        case (cmd.step)
            mps_pkg::STEP_N2:
            begin
                opa = 128'(count_reg);
                opb = 64'(count_reg);
            end
            mps_pkg::STEP_NS2:
            begin
                opa = 128'(count_reg);
                opb = 64'(sq_reg);
            end
            mps_pkg::STEP_S1SQ:
            begin
                opa = 128'(sum_reg);
                opb = 64'(sum_reg);
            end
            mps_pkg::STEP_MEAN:
            begin
                arith_op = mps_pkg::OP_DIV;
                opa      = 128'({sum_reg, 16'd0});
                opb      = 64'(count_reg);
            end
            mps_pkg::STEP_VAR:
            begin
                arith_op = mps_pkg::OP_DIV;
                opa      = 128'({d_reg, 16'd0});
                opb      = n2_reg;
            end
            mps_pkg::STEP_T1:
            begin
                opa = 128'(n2_reg);
                opb = 64'(cube_reg);
            end
            mps_pkg::STEP_N3S1:
            begin
                opa = 128'(n_times3);
                opb = 64'(sum_reg);
            end
            mps_pkg::STEP_T2:
            begin
                opa = 128'(tmp_reg);
                opb = 64'(sq_reg);
            end
            mps_pkg::STEP_T3:
            begin
                opa = 128'(s1sq_reg);
                opb = 64'({sum_reg, 1'b0});
            end
            mps_pkg::STEP_U:
            begin
                arith_op = mps_pkg::OP_DIV;
                opa      = {t_mag[111:0], 16'd0};
                opb      = d_reg;
            end
            mps_pkg::STEP_SQRT:
            begin
                arith_op = mps_pkg::OP_SQRT;
                opa      = 128'({d_reg, 32'd0});
            end
            mps_pkg::STEP_V:
            begin
                arith_op = mps_pkg::OP_DIV;
                opa      = {u_reg[111:0], 16'd0};
                opb      = 64'(s_reg);
            end
            default:
            begin
                arith_op = mps_pkg::OP_MUL;
            end
        endcase
    end

    mps_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.arith_start),
        .op    (arith_op),
        .opa   (opa),
        .opb   (opb),
        .done  (arith_done),
        .res   (arith_res)
    );

    // Capture each step's result; T1, T2 and T3 share t_reg, and S1SQ also forms d_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else if (arith_done && (cmd.step == mps_pkg::STEP_S1SQ))
        begin
            d_reg <= ns2_reg - arith_res[63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (arith_done)
        begin
            case (cmd.step)
                mps_pkg::STEP_N2:   n2_reg   <= arith_res[63:0];
                mps_pkg::STEP_NS2:  ns2_reg  <= arith_res[63:0];
                mps_pkg::STEP_S1SQ: s1sq_reg <= arith_res[63:0];
                mps_pkg::STEP_MEAN: mean_reg <= arith_res[23:0];
                mps_pkg::STEP_VAR:  var_reg  <= arith_res[29:0];
                mps_pkg::STEP_T1:   t_reg    <= arith_res;
                mps_pkg::STEP_N3S1: tmp_reg  <= arith_res[63:0];
                mps_pkg::STEP_T2:   t_reg    <= t_reg - arith_res;
                mps_pkg::STEP_T3:   t_reg    <= t_reg + arith_res;
                mps_pkg::STEP_U:    u_reg    <= arith_res;
                mps_pkg::STEP_SQRT: s_reg    <= arith_res[47:0];
                mps_pkg::STEP_V:    v_reg    <= arith_res;
                default:            v_reg    <= v_reg;
            endcase
        end
    end

    // Skewness: saturate the magnitude, then apply the sign.
    always_comb
    begin
        neg      = t_reg[127];
        lim      = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat      = (|u_reg[127:112]) || (|v_reg[127:32]) || (v_reg[31:0] > lim);
        skew_mag = sat ? lim : v_reg[31:0];
    end

    // Result assembly.
    always_comb
    begin
        result_next.pixel_count    = count_reg;
        result_next.min_value      = min_reg;
        result_next.max_value      = max_reg;
        result_next.sum_total      = sum_reg;
        result_next.sum_of_squares = sq_reg;
        result_next.positive_count = pos_reg;
        result_next.zero_count     = zero_reg;
        result_next.mode_value     = mode_reg;
        result_next.mean_q16       = '0;
        result_next.variance_q16   = '0;
        result_next.skewness_q16   = '0;
        if (n_zero)
        begin
            result_next.status = mps_pkg::STATUS_EMPTY;
        end
        else if (d_zero)
        begin
            result_next.status   = mps_pkg::STATUS_FLAT;
            result_next.mean_q16 = mean_reg;
        end
        else
        begin
            result_next.status       = mps_pkg::STATUS_OK;
            result_next.mean_q16     = mean_reg;
            result_next.variance_q16 = var_reg;
            result_next.skewness_q16 = neg ? (~skew_mag + 32'd1) : skew_mag;
        end
    end

    // Output register; a new result loads only when the old one has gone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

// ===== sv/mps_ctrl.sv =====
module mps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  mps_pkg::dp_status_t  status,
    output mps_pkg::dp_cmd_t     cmd
);

    mps_pkg::ctrl_state_t state_reg;
    mps_pkg::ctrl_state_t state_next;
    mps_pkg::step_t       step_reg;
    mps_pkg::step_t       step_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 skip;

    // A step is skipped when its divisor is zero; the result is formed at once.
    assign skip = ((step_reg == mps_pkg::STEP_MEAN) && status.n_zero) ||
                  ((step_reg == mps_pkg::STEP_VAR) && status.d_zero);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mps_pkg::ST_IDLE;
            step_reg  <= mps_pkg::STEP_N2;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        case (state_reg)
            mps_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    last_next = status.last;
                    if (status.take)
                    begin
                        state_next = mps_pkg::ST_HIST;
                    end
                    else if (status.last)
                    begin
                        state_next = mps_pkg::ST_SCAN;
                    end
                end
            end
            mps_pkg::ST_HIST:
            begin
                state_next = last_reg ? mps_pkg::ST_SCAN : mps_pkg::ST_IDLE;
            end
            mps_pkg::ST_SCAN:
            begin
                step_next = mps_pkg::STEP_N2;
                if (status.scan_end)
                begin
                    state_next = mps_pkg::ST_START;
                end
            end
            mps_pkg::ST_START:
            begin
                state_next = skip ? mps_pkg::ST_FORM : mps_pkg::ST_WAIT;
            end
            mps_pkg::ST_WAIT:
            begin
                if (status.arith_done)
                begin
                    if (step_reg == mps_pkg::STEP_V)
                    begin
                        state_next = mps_pkg::ST_FORM;
                    end
                    else
                    begin
                        step_next  = mps_pkg::step_t'(step_reg + 4'd1);
                        state_next = mps_pkg::ST_START;
                    end
                end
            end
            mps_pkg::ST_FORM:
            begin
                if (status.out_free)
                begin
                    state_next = mps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mps_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        sample_ready    = (state_reg == mps_pkg::ST_IDLE);
        cmd.accept      = (state_reg == mps_pkg::ST_IDLE) && sample_valid && status.take;
        cmd.hist_wr     = (state_reg == mps_pkg::ST_HIST);
        cmd.scan_run    = (state_reg == mps_pkg::ST_SCAN);
        cmd.arith_start = (state_reg == mps_pkg::ST_START) && !skip;
        cmd.step        = step_reg;
        cmd.load_result = (state_reg == mps_pkg::ST_FORM) && status.out_free;
        cmd.clear       = (state_reg == mps_pkg::ST_FORM) && status.out_free;
    end

endmodule

// ===== sv/masked_pixel_statistics.sv =====
// Masked pixel statistics for one 8-bit image channel.
// Input channel sample (sample_valid/sample_ready): one pixel per beat with its
// selected flag and a last flag that closes the frame. Selected pixels update a
// 256-bin histogram and the moment accumulators; once 2^24 pixels are counted,
// further ones are ignored.
// A selected pixel is read from the histogram, then written back, before the
// next beat is taken; an unselected pixel needs no histogram access. The
// histogram memory port sets this sequence. After the last beat the block scans
// the histogram for the mode, then runs mean, variance and skewness on one
// shared shift-and-add unit: seven 64-step products, four 128-step divisions and
// a 48-step square root, cut short at a zero divisor, while sample_ready is low.
// Output channel result (result_valid/result_ready): one beat per frame, held
// in an output register until taken. Pixels of the next frame are accepted
// while it waits; a stalled receiver holds the block at the next frame's result.
// Reset (rst_n, asynchronous) clears all accumulators and histogram valid bits
// at once; no clearing pass is needed, and the block is ready out of reset.
module masked_pixel_statistics (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  mps_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_ready,
    output mps_pkg::result_t  result
);

    mps_pkg::dp_cmd_t    cmd;
    mps_pkg::dp_status_t status;

    mps_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    mps_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== sv/mps_checker.sv =====
module mps_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input mps_pkg::result_t  result
);

    // A stalled result beat stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

    // An empty frame reports the reset values.
    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == mps_pkg::STATUS_EMPTY) |->
            (result.pixel_count == 25'd0) && (result.min_value == 8'd255) &&
            (result.max_value == 8'd0) && (result.mean_q16 == 24'd0))
        else $error("empty frame with non-reset statistics");

    // Every counted pixel is either zero or positive.
    a_count_split: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (26'(result.positive_count) + 26'(result.zero_count)) ==
            26'(result.pixel_count))
        else $error("positive and zero counts do not add up");

    // A frame with pixels has its minimum at or below its maximum.
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((result.status == mps_pkg::STATUS_OK) ||
                         (result.status == mps_pkg::STATUS_FLAT)) |->
            result.min_value <= result.max_value)
        else $error("minimum above maximum");

endmodule

bind masked_pixel_statistics mps_checker u_mps_checker (.*);

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             sample_valid = 1'b0;
    logic             sample_ready;
    mps_pkg::sample_t sample = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    mps_pkg::result_t result;

    masked_pixel_statistics dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #4 clk = ~clk;

    // Pixels waiting to be offered and frame results still owed by the block.
    mps_pkg::sample_t pixel_queue[$];
    mps_pkg::result_t frame_results[$];

    // Model copy of the accumulators.
    logic [63:0] bin_count [mps_pkg::BINS];
    logic [63:0] n_acc, s1_acc, s2_acc, s3_acc, lo_acc, hi_acc, pos_acc, zer_acc;

    int unsigned mismatches = 0;
    int unsigned frames_seen = 0;
    int unsigned pixels_sent = 0;
    bit          sender_done = 1'b0;

    function automatic void clear_frame();
        foreach (bin_count[i]) bin_count[i] = '0;
        n_acc = '0; s1_acc = '0; s2_acc = '0; s3_acc = '0;
        lo_acc = 64'd255; hi_acc = '0; pos_acc = '0; zer_acc = '0;
    endfunction

    // Accumulate one pixel and, on the last one, form the frame statistics.
    function automatic void accumulate_pixel(mps_pkg::sample_t s);
        logic [63:0]  p, mode, best, n2, d, mean, vari, skew, lim, sq, k3, s1sq, s1x2;
        logic [127:0] t, mag, u, v, dw, cc;
        logic [1:0]   status;
        logic         neg, sat;
        mps_pkg::result_t r;
        p = {56'd0, s.pixel};
        mean = '0; vari = '0; skew = '0; status = mps_pkg::STATUS_OK; mode = '0;
        if (s.selected && n_acc < (64'd1 << mps_pkg::MAX_PIXELS_LOG2)) begin
            bin_count[s.pixel] = bin_count[s.pixel] + 1;
            n_acc = n_acc + 1;
            s1_acc = s1_acc + p;
            s2_acc = s2_acc + p * p;
            s3_acc = s3_acc + p * p * p;
            if (p < lo_acc) lo_acc = p;
            if (p > hi_acc) hi_acc = p;
            if (p > 0) pos_acc = pos_acc + 1;
            else zer_acc = zer_acc + 1;
        end
        if (!s.last) return;

        best = bin_count[0];
        for (int i = 1; i < mps_pkg::BINS; i++)
            if (bin_count[i] > best) begin
                best = bin_count[i];
                mode = 64'(i);
            end

        if (n_acc == 0) begin
            status = mps_pkg::STATUS_EMPTY;
        end else begin
            n2 = n_acc * n_acc;
            mean = (s1_acc << 16) / n_acc;
            d = n_acc * s2_acc - s1_acc * s1_acc;
            if (d == 0) begin
                status = mps_pkg::STATUS_FLAT;
            end else begin
                vari = (d / n2) * 64'd65536 + ((d % n2) << 16) / n2;
                k3 = 64'd3 * n_acc * s1_acc;
                s1sq = s1_acc * s1_acc;
                s1x2 = 64'd2 * s1_acc;
                t = {64'd0, n2} * {64'd0, s3_acc} - {64'd0, k3} * {64'd0, s2_acc}
                    + {64'd0, s1sq} * {64'd0, s1x2};
                neg = t[127];
                mag = neg ? -t : t;
                u = (mag << 16) / {64'd0, d};
                dw = {64'd0, d} << 32;
                sq = '0;
                for (int b = 63; b >= 0; b--) begin
                    cc = {64'd0, sq | (64'd1 << b)} * {64'd0, sq | (64'd1 << b)};
                    if (cc <= dw) sq = sq | (64'd1 << b);
                end
                lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                sat = 1'b0;
                if (u[127:112] != 0 || sq == 0) begin
                    sat = 1'b1;
                end else begin
                    v = (u << 16) / {64'd0, sq};
                    if (v > {64'd0, lim}) sat = 1'b1;
                    else skew = v[63:0];
                end
                if (sat) skew = lim;
                if (neg) skew = {32'd0, -skew[31:0]};
            end
        end

        r.pixel_count    = n_acc[24:0];
        r.min_value      = lo_acc[7:0];
        r.max_value      = hi_acc[7:0];
        r.mean_q16       = mean[23:0];
        r.variance_q16   = vari[29:0];
        r.sum_total      = s1_acc[31:0];
        r.sum_of_squares = s2_acc[39:0];
        r.positive_count = pos_acc[24:0];
        r.zero_count     = zer_acc[24:0];
        r.mode_value     = mode[7:0];
        r.skewness_q16   = skew[31:0];
        r.status         = status;
        frame_results.insert(frame_results.size(), r);
        clear_frame();
    endfunction

    function automatic int unsigned random_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch in frame %0d, %s: expected %0d (0x%0h), got %0d (0x%0h)",
                         frames_seen, name, want, want, got, got);
        end
    endfunction

    // Driver: offers queued pixels with random gaps, holding each until taken.
    int unsigned send_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (sample_valid && sample_ready) begin
                accumulate_pixel(sample);
                pixels_sent <= pixels_sent + 1;
            end
            if (!sample_valid || sample_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    sample_valid <= 1'b0;
                end else if (pixel_queue.size() > 0) begin
                    sample <= pixel_queue[0];
                    pixel_queue.delete(0);
                    sample_valid <= 1'b1;
                    send_gap <= random_gap();
                end else begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on its own, so later frames back up.
    int unsigned hold_cycles = 0;
    bit          hold_done = 1'b0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (!hold_done && frames_seen == 12) begin
                hold_done <= 1'b1;
                hold_cycles <= 4000;
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
            end
        end
    end

    // Monitor: random back-pressure and the result check.
    int unsigned recv_gap = 0;
    always @(posedge clk) begin
        mps_pkg::result_t want;
        if (rst_n) begin
            if (result_valid && result_ready) begin
                if (frame_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result beat after frame %0d", frames_seen);
                end else begin
                    want = frame_results[0];
                    frame_results.delete(0);
                    compare_field("pixel_count", want.pixel_count, result.pixel_count);
                    compare_field("min_value", want.min_value, result.min_value);
                    compare_field("max_value", want.max_value, result.max_value);
                    compare_field("mean_q16", want.mean_q16, result.mean_q16);
                    compare_field("variance_q16", want.variance_q16, result.variance_q16);
                    compare_field("sum_total", want.sum_total, result.sum_total);
                    compare_field("sum_of_squares", want.sum_of_squares,
                                  result.sum_of_squares);
                    compare_field("positive_count", want.positive_count,
                                  result.positive_count);
                    compare_field("zero_count", want.zero_count, result.zero_count);
                    compare_field("mode_value", want.mode_value, result.mode_value);
                    compare_field("skewness_q16", want.skewness_q16, result.skewness_q16);
                    compare_field("status", want.status, result.status);
                end
                frames_seen <= frames_seen + 1;
            end
            if (hold_cycles > 0) begin
                result_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                result_ready <= 1'b0;
            end else begin
                result_ready <= 1'b1;
                recv_gap <= random_gap();
            end
        end
    end

    function automatic mps_pkg::sample_t make_pixel(logic [7:0] px, logic sel, logic lst);
        mps_pkg::sample_t s;
        s.pixel = px;
        s.selected = sel;
        s.last = lst;
        return s;
    endfunction

    // Queue one frame of random content; flavour picks the value spread.
    task automatic queue_random_frame(int unsigned len);
        int unsigned flavour, base;
        logic [7:0]  px;
        flavour = $urandom_range(5);
        base = $urandom_range(255);
        for (int unsigned i = 0; i < len; i++) begin
            case (flavour)
                0: px = 8'(base);
                1: px = ($urandom_range(1)) ? 8'd0 : 8'd255;
                2: px = 8'(base + $urandom_range(3));
                3: px = ($urandom_range(9) == 0) ? 8'd255 : 8'(
                        $urandom_range(4));
                default: px = 8'($urandom);
            endcase
            pixel_queue.insert(pixel_queue.size(),
                               make_pixel(px, $urandom_range(9) != 0, i == len - 1));
        end
    endtask

    task automatic queue_pixel(logic [7:0] px, logic sel, logic lst);
        pixel_queue.insert(pixel_queue.size(), make_pixel(px, sel, lst));
    endtask

    task automatic wait_all_done();
        while (pixel_queue.size() > 0 || sample_valid || frame_results.size() > 0)
            @(posedge clk);
    endtask

    initial begin
        int unsigned budget, len;
        clear_frame();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames: empty, single pixel, constant, extremes, mode ties.
        queue_pixel(8'd200, 1'b0, 1'b1);
        queue_pixel(8'd255, 1'b1, 1'b1);
        queue_pixel(8'd0, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++) queue_pixel(8'd77, 1'b1, i == 3);
        queue_pixel(8'd0, 1'b1, 1'b0);
        queue_pixel(8'd255, 1'b1, 1'b0);
        queue_pixel(8'd9, 1'b0, 1'b1);
        queue_pixel(8'd40, 1'b1, 1'b0);
        queue_pixel(8'd10, 1'b1, 1'b0);
        queue_pixel(8'd40, 1'b1, 1'b0);
        queue_pixel(8'd10, 1'b1, 1'b0);
        queue_pixel(8'd255, 1'b1, 1'b0);
        queue_pixel(8'd1, 1'b1, 1'b1);
        for (int i = 0; i < 5; i++)
            queue_pixel(i == 4 ? 8'd250 : 8'd1, 1'b1, i == 4);
        budget = 24;

        // Random frames, mostly short, in two halves with a full drain between.
        for (int phase = 0; phase < 2; phase++) begin
            while (budget < 775 * (phase + 1)) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(200, 40)
                                               : $urandom_range(30, 1);
                queue_random_frame(len);
                budget += len;
            end
            if (phase == 0) wait_all_done();
        end
        wait_all_done();
        repeat (1500) @(posedge clk);

        $display("Sent %0d pixels over %0d frames, including empty, constant and extreme frames.",
                 pixels_sent, frames_seen);
        if (mismatches == 0 && frame_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #80ms;
        $display("Timed out with %0d results outstanding", frame_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/mps_pkg.sv
sv/mps_ram.sv
sv/mps_arith.sv
sv/mps_datapath.sv
sv/mps_ctrl.sv
sv/masked_pixel_statistics.sv
sv/mps_checker.sv
bench/tb.sv
